FILE: hdl/deq_pkg.sv
// ----------------------------------------------------------------------------
// Deque package
// Request, response and cell control types, command and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int CMD_W   = 3;
   localparam int VALUE_W = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W = 5;

   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [VALUE_W-1:0] element_value;
   } deq_req_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  popped_value;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  element_count;
   } deq_rsp_type;

   typedef struct packed {
      logic shift_right;
      logic shift_left;
      logic write_back;
      logic tail_grab;
      logic carry_shift;
      logic clear;
   } deq_op_type;

endpackage

`default_nettype wire

FILE: hdl/deq_cell.sv
// ----------------------------------------------------------------------------
// Deque cell
// One word slot of the chain with a valid bit and a return-path carry stage.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_cell #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  deq_pkg::deq_op_type   op,
   input  logic [DATA_WIDTH-1:0] word,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic                  left_valid,
   input  logic [DATA_WIDTH-1:0] right_data,
   input  logic                  right_valid,
   input  logic [DATA_WIDTH-1:0] right_carry,
   output logic [DATA_WIDTH-1:0] data,
   output logic                  valid,
   output logic [DATA_WIDTH-1:0] carry
);
   import deq_pkg::*;

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic                  valid_ff;
   logic                  valid_in;
   logic [DATA_WIDTH-1:0] carry_ff;
   logic [DATA_WIDTH-1:0] carry_in;
   logic                  tail;

   assign tail = valid_ff && !right_valid;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      carry_in = carry_ff;
      if (op.clear) begin
         valid_in = 1'b0;
      end else if (op.shift_right) begin
         data_in  = left_data;
         valid_in = left_valid;
      end else if (op.shift_left) begin
         data_in  = right_data;
         valid_in = right_valid;
      end else if (op.write_back) begin
         if (!valid_ff && left_valid) begin
            data_in  = word;
            valid_in = 1'b1;
         end
      end else if (op.tail_grab && tail) begin
         valid_in = 1'b0;
      end
      if (op.tail_grab || op.carry_shift) begin
         carry_in = (op.tail_grab && tail) ? data_ff : right_carry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff  <= data_in;
      carry_ff <= carry_in;
   end

   assign data  = data_ff;
   assign valid = valid_ff;
   assign carry = carry_ff;

endmodule

`default_nettype wire

FILE: hdl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// Deque controller
// Command decode, element count, pop-back return wait and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  deq_pkg::deq_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output deq_pkg::deq_rsp_type  rsp_data,
   input  logic [DATA_WIDTH-1:0] front_data,
   input  logic [DATA_WIDTH-1:0] carry_data,
   output deq_pkg::deq_op_type   op
);
   import deq_pkg::*;

   localparam int CountW = $clog2(DEPTH + 1);
   localparam int IdxW   = $clog2(DEPTH);
   localparam int OutW   = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

   localparam logic [0:0] ST_IDLE = 1'b0;
   localparam logic [0:0] ST_WAIT = 1'b1;

   logic [0:0]            state_ff;
   logic [0:0]            state_in;
   logic [CountW-1:0]     count_ff;
   logic [CountW-1:0]     count_in;
   logic [IdxW-1:0]       wait_ff;
   logic [IdxW-1:0]       wait_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   deq_rsp_type           rsp_data_ff;
   deq_rsp_type           rsp_data_in;
   logic                  out_free;
   logic                  accept;
   logic                  full;
   logic                  empty;
   logic                  load;
   logic [DATA_WIDTH-1:0] pop_word;
   logic [STATUS_W-1:0]   status;
   deq_rsp_type           load_data;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CountW'(DEPTH));
   assign empty     = (count_ff == '0);

   always_comb begin
      op       = '0;
      state_in = state_ff;
      count_in = count_ff;
      wait_in  = wait_ff;
      load     = 1'b0;
      pop_word = '0;
      status   = STATUS_OK;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               load = 1'b1;
               case (req_data.command)
                  CMD_PUSH_BACK: begin
                     if (full) begin
                        status = STATUS_FULL;
                     end else begin
                        op.write_back = 1'b1;
                        count_in      = count_ff + 1'b1;
                     end
                  end
                  CMD_PUSH_FRONT: begin
                     if (full) begin
                        status = STATUS_FULL;
                     end else begin
                        op.shift_right = 1'b1;
                        count_in       = count_ff + 1'b1;
                     end
                  end
                  CMD_POP_FRONT: begin
                     if (empty) begin
                        status = STATUS_EMPTY;
                     end else begin
                        op.shift_left = 1'b1;
                        pop_word      = front_data;
                        count_in      = count_ff - 1'b1;
                     end
                  end
                  CMD_POP_BACK: begin
                     if (empty) begin
                        status = STATUS_EMPTY;
                     end else begin
                        load         = 1'b0;
                        op.tail_grab = 1'b1;
                        count_in     = count_ff - 1'b1;
                        wait_in      = IdxW'(count_ff - 1'b1);
                        state_in     = ST_WAIT;
                     end
                  end
                  CMD_CLEAR: begin
                     op.clear = 1'b1;
                     count_in = '0;
                  end
                  default: begin
                     status = STATUS_OK;
                  end
               endcase
            end
         end
         ST_WAIT: begin
            if (wait_ff != '0) begin
               op.carry_shift = 1'b1;
               wait_in        = wait_ff - 1'b1;
            end else if (out_free) begin
               load     = 1'b1;
               pop_word = carry_data;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      load_data.popped_value  = VALUE_W'(pop_word[OutW-1:0]);
      load_data.status        = status;
      load_data.element_count = COUNT_W'(count_in);
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = load ? load_data : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(DEPTH))
      else $error("element count above depth");

   a_pop_back_wait: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.command == CMD_POP_BACK) && !empty |=> state_ff == ST_WAIT)
      else $error("pop back did not enter return wait");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_FULL)
         |-> rsp_data.element_count == COUNT_W'(DEPTH))
      else $error("full status with count below depth");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_EMPTY) |-> rsp_data.element_count == '0)
      else $error("empty status with nonzero count");

endmodule

`default_nettype wire

FILE: hdl/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// Double-ended queue core
// Deque of DEPTH words kept in a chain of cells, front word in the first cell.
//
// Request channel (req_valid, req_stall, req_data): command and word. Push back,
// push front, pop front, pop back or clear. Response channel (rsp_valid,
// rsp_stall, rsp_data): popped word, status and element count, one per request.
// Push front and pop front shift the whole chain by one cell; push back fills
// the first empty cell. These and clear answer in the cycle after acceptance and
// sustain one request per cycle while the response is not stalled.
// Pop back frees the last occupied cell and walks its word toward the first
// cell along the carry chain, one cell per cycle, and stalls requests until
// its response is loaded. A refused push (full) or pop (empty) changes nothing
// and answers in the cycle after acceptance.
// Reset empties the queue and drops any pending response. While rsp_stall is
// high the response register holds; one more request may be accepted only
// when the register is free or being taken in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_core #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  deq_pkg::deq_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output deq_pkg::deq_rsp_type rsp_data
);
   import deq_pkg::*;

   deq_op_type            op;
   logic [DATA_WIDTH-1:0] word;
   logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
   logic                  cell_valid [DEPTH];
   logic [DATA_WIDTH-1:0] cell_carry [DEPTH];

   assign word = DATA_WIDTH'(req_data.element_value);

   deq_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .front_data (cell_data[0]),
      .carry_data (cell_carry[0]),
      .op         (op)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic                  left_valid;
      logic [DATA_WIDTH-1:0] right_data;
      logic                  right_valid;
      logic [DATA_WIDTH-1:0] right_carry;

      if (i == 0) begin : g_first
         assign left_data  = word;
         assign left_valid = 1'b1;
      end else begin : g_inner_left
         assign left_data  = cell_data[i-1];
         assign left_valid = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data  = '0;
         assign right_valid = 1'b0;
         assign right_carry = '0;
      end else begin : g_inner_right
         assign right_data  = cell_data[i+1];
         assign right_valid = cell_valid[i+1];
         assign right_carry = cell_carry[i+1];
      end

      deq_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (op),
         .word        (word),
         .left_data   (left_data),
         .left_valid  (left_valid),
         .right_data  (right_data),
         .right_valid (right_valid),
         .right_carry (right_carry),
         .data        (cell_data[i]),
         .valid       (cell_valid[i]),
         .carry       (cell_carry[i])
      );
   end

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Double-ended queue core testbench
// Drives push, pop, clear and unused commands through the request channel and
// checks every response against a behavioral deque kept in the testbench.
// Directed tests cover empty and full refusals, index wrap and clear; random
// traffic alternates growing and shrinking phases with random gaps and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import deq_pkg::*;

   localparam int DEPTH         = DEPTH_DEFAULT;
   localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
   localparam int ROUNDS        = 10;
   localparam int ROUND_ITEMS   = 50;

   localparam logic [CMD_W-1:0]   CMD_UNUSED_FIRST = 3'd5;
   localparam logic [CMD_W-1:0]   CMD_UNUSED_LAST  = 3'd7;
   localparam logic [VALUE_W-1:0] WORD_ZERO        = '0;
   localparam logic [VALUE_W-1:0] WORD_ONES        = '1;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   deq_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   deq_rsp_type rsp_data;

   logic [VALUE_W-1:0] deque_words [DEPTH] = '{default: '0};
   int                 front_slot = 0;
   int                 back_slot  = 0;
   int                 word_count = 0;
   deq_rsp_type        expected_responses [$];
   deq_rsp_type        expected_now;
   int                 mismatch_count = 0;
   bit                 no_idle = 1'b0;

   double_ended_queue_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic deq_rsp_type deque_apply(logic [CMD_W-1:0] cmd,
                                                logic [VALUE_W-1:0] word);
      deq_rsp_type rsp;
      rsp = '0;
      rsp.status = STATUS_OK;
      case (cmd)
         CMD_PUSH_BACK: begin
            if (word_count >= DEPTH) begin
               rsp.status = STATUS_FULL;
            end else begin
               deque_words[back_slot] = word;
               back_slot = (back_slot + 1) % DEPTH;
               word_count++;
            end
         end
         CMD_PUSH_FRONT: begin
            if (word_count >= DEPTH) begin
               rsp.status = STATUS_FULL;
            end else begin
               front_slot = (front_slot + DEPTH - 1) % DEPTH;
               deque_words[front_slot] = word;
               word_count++;
            end
         end
         CMD_POP_FRONT: begin
            if (word_count == 0) begin
               rsp.status = STATUS_EMPTY;
            end else begin
               rsp.popped_value = deque_words[front_slot];
               front_slot = (front_slot + 1) % DEPTH;
               word_count--;
            end
         end
         CMD_POP_BACK: begin
            if (word_count == 0) begin
               rsp.status = STATUS_EMPTY;
            end else begin
               back_slot = (back_slot + DEPTH - 1) % DEPTH;
               rsp.popped_value = deque_words[back_slot];
               word_count--;
            end
         end
         CMD_CLEAR: begin
            front_slot = 0;
            back_slot  = 0;
            word_count = 0;
         end
         default: begin
         end
      endcase
      rsp.element_count = word_count[COUNT_W-1:0];
      return rsp;
   endfunction

   task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                  logic [VALUE_W-1:0] want);
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_request(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] word);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{command: cmd, element_value: word};
      do @(posedge clock); while (req_stall);
      expected_responses.push_back(deque_apply(cmd, word));
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_responses.size() != 0);
      @(posedge clock);
   endtask

   task automatic test_empty_and_unused();
      send_request(CMD_POP_FRONT, WORD_ONES);
      send_request(CMD_POP_BACK, WORD_ONES);
      send_request(CMD_UNUSED_LAST, WORD_ONES);
   endtask

   task automatic test_fill_and_wrap();
      send_request(CMD_PUSH_FRONT, WORD_ONES);
      send_request(CMD_PUSH_BACK, WORD_ZERO);
      for (int i = 0; i < DEPTH - 2; i++) begin
         send_request((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                      (i % 2) ? 32'hAAAA_AAAA : 32'h5555_5555);
      end
      // hold off until the full queue has answered
      wait_for_responses();
      send_request(CMD_PUSH_BACK, WORD_ONES);
      send_request(CMD_PUSH_FRONT, WORD_ZERO);
      send_request(CMD_POP_BACK, WORD_ZERO);
      send_request(CMD_POP_FRONT, WORD_ZERO);
      send_request(CMD_CLEAR, WORD_ONES);
      send_request(CMD_POP_FRONT, WORD_ZERO);
   endtask

   task automatic test_random_traffic();
      int                 pick;
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] word;
      for (int round = 0; round < ROUNDS; round++) begin
         no_idle = (round % 4 == 3);
         if (round == ROUNDS / 2) begin
            wait_for_responses();
         end
         for (int n = 0; n < ROUND_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
               cmd = CMD_CLEAR;
            end else if (pick < 4) begin
               cmd = CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
            end else if ((pick < 70) == (round % 2 == 0)) begin
               cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            end else begin
               cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
            end
            pick = $urandom_range(0, 9);
            word = (pick == 0) ? WORD_ZERO : (pick == 1) ? WORD_ONES : $urandom;
            send_request(cmd, word);
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin : response_stall
      int hold;
      @(posedge clock);
      forever begin
         hold = draw_wait();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_responses.size() == 0) begin
            report_mismatch("response with no request pending", rsp_data.popped_value,
                            WORD_ZERO);
         end else begin
            expected_now = expected_responses.pop_front();
            if (rsp_data.popped_value !== expected_now.popped_value) begin
               report_mismatch("popped_value", rsp_data.popped_value,
                               expected_now.popped_value);
            end
            if (rsp_data.status !== expected_now.status) begin
               report_mismatch("status", VALUE_W'(rsp_data.status),
                               VALUE_W'(expected_now.status));
            end
            if (rsp_data.element_count !== expected_now.element_count) begin
               report_mismatch("element_count", VALUE_W'(rsp_data.element_count),
                               VALUE_W'(expected_now.element_count));
            end
         end
      end
   end

   initial begin : run_tests
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_unused();
      test_fill_and_wrap();
      test_random_traffic();
      wait_for_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_responses.size() != 0) begin
         report_mismatch("responses missing", expected_responses.size(), 0);
      end
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
